>>> rtl/lzpc_pkg.sv
package lzpc_pkg;

  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_FRAME   = 3'd1;
  localparam logic [2:0] KIND_SETUP   = 3'd2;
  localparam logic [2:0] KIND_BYTE    = 3'd3;
  localparam logic [2:0] KIND_PALETTE = 3'd4;

  localparam logic [2:0] HIT_BACKGROUND = 3'd4;

  localparam logic [23:0] UNIT_STEP = 24'h010000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  layer;
    logic [23:0] x_origin;
    logic [23:0] y_origin;
    logic [23:0] x_step;
    logic [23:0] y_step;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic        line_end;
    logic        hit;
    logic [2:0]  hit_layer;
    logic [7:0]  pixel;
  } item_t;

endpackage

>>> rtl/layered_zoom_plane_compositor.sv
// Composes one 24-bit pixel per clock, while the output is not stalled, from
// up to four scrolled and zoomed 8-bit bitmap planes. Every request runs down
// a chain of plane cells, one per plane, then through the palette stage and
// the output register; each cell holds its own plane memory and accumulators
// and makes one registered read per request, so the block takes a request
// every cycle unless a stalled output holds the chain back. There are CELLS
// cells, CELLS being the smaller of PLANE_COUNT and four. Setup, frame start,
// byte and palette writes travel the same chain and so act in order with the
// pixel ticks around them. A stalled output holds the chain back only once every stage is full.
module layered_zoom_plane_compositor
  import lzpc_pkg::*;
#(
  parameter int unsigned PLANE_SIZE_LOG2 = 8,
  parameter int unsigned PLANE_COUNT     = 4,
  parameter int unsigned PALETTE_DEPTH   = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // layer, x_origin, y_origin, x_step, y_step, write_address, write_data
  input  logic [135:0] in_tdata,
  // kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // red, green, blue
  output logic [23:0]  out_tdata,
  // hit_layer
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int unsigned CELLS = (PLANE_COUNT < 4) ? PLANE_COUNT : 4;

  localparam logic [1:0] CFG_LAYER_ENABLE = 2'd0;
  localparam logic [1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND   = 2'd2;

  logic [3:0]  layer_enable_r;
  logic [9:0]  line_width_r;
  logic [23:0] background_r;
  logic [9:0]  col_cnt_r;

  logic [9:0] col_inc;
  logic       line_last;
  logic       in_accept;

  item_t chain_item  [CELLS+1];
  logic  chain_valid [CELLS+1];
  logic  chain_ready [CELLS+1];

  assign col_inc   = col_cnt_r + 10'd1;
  assign line_last = (col_inc >= line_width_r);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_enable_r <= 4'd15;
      line_width_r   <= 10'd424;
      background_r   <= 24'h404000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYER_ENABLE: layer_enable_r <= cfg_data[3:0];
        CFG_LINE_WIDTH:   line_width_r   <= cfg_data[9:0];
        CFG_BACKGROUND:   background_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
    end else if (in_accept) begin
      case (in_tuser)
        KIND_PIXEL: col_cnt_r <= line_last ? 10'd0 : col_inc;
        KIND_FRAME: col_cnt_r <= 10'd0;
        default: ;
      endcase
    end
  end

  always_comb begin
    chain_item[0].kind          = in_tuser;
    chain_item[0].layer         = in_tdata[1:0];
    chain_item[0].x_origin      = in_tdata[25:2];
    chain_item[0].y_origin      = in_tdata[49:26];
    chain_item[0].x_step        = in_tdata[73:50];
    chain_item[0].y_step        = in_tdata[97:74];
    chain_item[0].write_address = in_tdata[113:98];
    chain_item[0].write_data    = in_tdata[129:114];
    chain_item[0].line_end      = line_last;
    chain_item[0].hit           = 1'b0;
    chain_item[0].hit_layer     = HIT_BACKGROUND;
    chain_item[0].pixel         = 8'd0;
  end

  assign chain_valid[0] = in_tvalid;
  assign in_tready      = chain_ready[0];

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    lzpc_cell #(
      .PLANE_SIZE_LOG2 (PLANE_SIZE_LOG2),
      .INDEX           (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .enable    (layer_enable_r[g]),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  lzpc_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_valid[CELLS]),
    .in_ready   (chain_ready[CELLS]),
    .in_item    (chain_item[CELLS]),
    .background (background_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == HIT_BACKGROUND || out_tuser < 3'(CELLS)))
    else $error("hit plane outside the built planes");

  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == KIND_PIXEL && line_last) |=> (col_cnt_r == 10'd0))
    else $error("column count not cleared at line end");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input held back without an output stall");

endmodule

>>> rtl/lzpc_cell.sv
module lzpc_cell
  import lzpc_pkg::*;
#(
  parameter int unsigned PLANE_SIZE_LOG2 = 8,
  parameter int unsigned INDEX           = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  enable,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int unsigned ACC_W       = PLANE_SIZE_LOG2 + 16;
  localparam int unsigned ADDR_W      = 2 * PLANE_SIZE_LOG2;
  localparam int unsigned PLANE_BYTES = 1 << ADDR_W;

  logic [7:0]       mem [PLANE_BYTES];
  logic             valid_r;
  item_t            item_r;
  logic [7:0]       rdata_r;
  logic [ACC_W-1:0] x_acc_r;
  logic [ACC_W-1:0] y_acc_r;
  logic [ACC_W-1:0] x_org_r;
  logic [ACC_W-1:0] y_org_r;
  logic [23:0]      x_step_r;
  logic [23:0]      y_step_r;

  logic              load;
  logic              mine;
  logic [ACC_W-1:0]  x_step_ext;
  logic [ACC_W-1:0]  y_step_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  assign in_ready   = !valid_r || out_ready;
  assign load       = in_valid && in_ready;
  assign out_valid  = valid_r;
  assign mine       = (in_item.layer == 2'(INDEX));
  assign x_step_ext = ACC_W'({{8{x_step_r[23]}}, x_step_r});
  assign y_step_ext = ACC_W'({{8{y_step_r[23]}}, y_step_r});
  assign rd_addr    = {y_acc_r[16 +: PLANE_SIZE_LOG2], x_acc_r[16 +: PLANE_SIZE_LOG2]};
  assign wr_addr    = ADDR_W'({16'd0, in_item.write_address});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      x_acc_r  <= '0;
      y_acc_r  <= '0;
      x_org_r  <= '0;
      y_org_r  <= '0;
      x_step_r <= UNIT_STEP;
      y_step_r <= UNIT_STEP;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (load) begin
        case (in_item.kind)
          KIND_PIXEL: begin
            if (in_item.line_end) begin
              x_acc_r <= x_org_r;
              y_acc_r <= y_acc_r + y_step_ext;
            end else begin
              x_acc_r <= x_acc_r + x_step_ext;
            end
          end
          KIND_FRAME: begin
            x_acc_r <= x_org_r;
            y_acc_r <= y_org_r;
          end
          KIND_SETUP: begin
            if (mine) begin
              x_org_r  <= ACC_W'({8'd0, in_item.x_origin});
              y_org_r  <= ACC_W'({8'd0, in_item.y_origin});
              x_step_r <= in_item.x_step;
              y_step_r <= in_item.y_step;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_item.kind == KIND_BYTE && mine) begin
      mem[wr_addr] <= in_item.write_data[7:0];
    end
    if (load) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // A plane above this one that already hit keeps the pixel.
  always_comb begin
    out_item = item_r;
    if (!item_r.hit && enable && rdata_r != 8'd0) begin
      out_item.hit       = 1'b1;
      out_item.hit_layer = 3'(INDEX);
      out_item.pixel     = rdata_r;
    end
  end

endmodule

>>> rtl/lzpc_palette.sv
module lzpc_palette
  import lzpc_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  input  logic [23:0] background,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  localparam int unsigned PIW = $clog2(PALETTE_DEPTH);

  logic [15:0] pal [PALETTE_DEPTH];
  logic        pal_valid_r;
  logic [2:0]  pal_kind_r;
  logic        pal_last_r;
  logic        pal_hit_r;
  logic [2:0]  pal_layer_r;
  logic        pal_oob_r;
  logic [15:0] pal_word_r;
  logic        out_valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [2:0]  hit_layer_r;
  logic        line_end_r;

  logic        load;
  logic        out_free;
  logic        pixel_ready;
  logic [15:0] word;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;
  logic [2:0]  hit_layer_nxt;

  assign out_free    = !out_valid_r || out_tready;
  assign pixel_ready = pal_valid_r && pal_kind_r == KIND_PIXEL;
  assign in_ready    = !pal_valid_r || pal_kind_r != KIND_PIXEL || out_free;
  assign load        = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (load && in_item.kind == KIND_PALETTE &&
        in_item.write_address < 16'(PALETTE_DEPTH)) begin
      pal[in_item.write_address[PIW-1:0]] <= in_item.write_data;
    end
    if (load) begin
      pal_word_r <= pal[in_item.pixel[PIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pal_kind_r  <= in_item.kind;
      pal_last_r  <= in_item.line_end;
      pal_hit_r   <= in_item.hit;
      pal_layer_r <= in_item.hit_layer;
      pal_oob_r   <= ({1'b0, in_item.pixel} >= 9'(PALETTE_DEPTH));
    end
  end

  // A byte beyond the palette still hits, but shows palette word zero.
  assign word = pal_oob_r ? 16'd0 : pal_word_r;

  always_comb begin
    if (pal_hit_r) begin
      red_nxt       = {word[15:12], 4'd0} + {4'd0, word[3:0]};
      green_nxt     = {word[11:8], 4'd0} + {4'd0, word[3:0]};
      blue_nxt      = {word[7:4], 4'd0} + {4'd0, word[3:0]};
      hit_layer_nxt = pal_layer_r;
    end else begin
      red_nxt       = background[23:16];
      green_nxt     = background[15:8];
      blue_nxt      = background[7:0];
      hit_layer_nxt = HIT_BACKGROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        pal_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= pixel_ready;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pixel_ready) begin
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      hit_layer_r <= hit_layer_nxt;
      line_end_r  <= pal_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {blue_r, green_r, red_r};
  assign out_tuser  = hit_layer_r;
  assign out_tlast  = line_end_r;

endmodule
